[rtl/ucdp_pkg.sv]
// ----------------------------------------------------------------------------
// ucdp_pkg
// shared types and constants for the configuration descriptor parser
// ----------------------------------------------------------------------------
`default_nettype none

package ucdp_pkg;

  localparam int MAX_INTERFACES = 8;
  localparam int MAX_ENDPOINTS  = 16;

  localparam int IF_CNT_W = $clog2(MAX_INTERFACES + 1);
  localparam int EP_CNT_W = $clog2(MAX_ENDPOINTS + 1);

  // descriptor type codes
  localparam logic [7:0] TYPE_CONFIG    = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // standard descriptor lengths
  localparam logic [7:0] STD_LEN_CONFIG    = 8'd9;
  localparam logic [7:0] STD_LEN_INTERFACE = 8'd9;
  localparam logic [7:0] STD_LEN_ENDPOINT  = 8'd7;

  // endpoint field masks
  localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
  localparam logic [7:0] EP_DIR_BIT     = 8'h80;
  localparam logic [7:0] XFER_TYPE_MASK = 8'h03;

  // number of bytes held from offsets 2..7
  localparam int HOLD_DEPTH = 6;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    KIND_CONFIG    = 2'd0,
    KIND_INTERFACE = 2'd1,
    KIND_ENDPOINT  = 2'd2,
    KIND_END       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  interface_slot;
    logic [3:0]  endpoint_slot;
    logic [7:0]  id_value;
    logic [7:0]  alt_or_type;
    logic [7:0]  iface_class;
    logic [7:0]  subclass_code;
    logic [7:0]  protocol_code;
    logic        direction_in;
    logic [15:0] ep_packet_size;
    logic [7:0]  poll_interval;
  } rec_t;

  typedef struct packed {
    logic       has_rec;
    rec_t       rec;
    logic       has_end;
    logic [3:0] end_count;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/ucdp_front.sv]
// ----------------------------------------------------------------------------
// ucdp_front
// byte tracker: follows descriptor boundaries and builds record and end commands
// ----------------------------------------------------------------------------
`default_nettype none

module ucdp_front
  import ucdp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       q_full,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  logic [7:0]          byte_position, byte_position_next;
  logic [7:0]          descriptor_length, descriptor_length_next;
  logic [7:0]          descriptor_type, descriptor_type_next;
  logic [IF_CNT_W-1:0] interface_count, interface_count_next;
  logic                have_interface, have_interface_next;
  logic [EP_CNT_W-1:0] endpoint_count, endpoint_count_next;
  logic                parse_halted, parse_halted_next;

  logic [7:0] field_hold [HOLD_DEPTH];
  logic       hold_we;
  logic [2:0] hold_idx;

  logic       accept;
  logic [7:0] pos_inc;

  assign accept = in_valid && !q_full;

  always_comb begin
    byte_position_next     = byte_position;
    descriptor_length_next = descriptor_length;
    descriptor_type_next   = descriptor_type;
    interface_count_next   = interface_count;
    have_interface_next    = have_interface;
    endpoint_count_next    = endpoint_count;
    parse_halted_next      = parse_halted;
    hold_we                = 1'b0;
    hold_idx               = 3'(byte_position - 8'd2);
    pos_inc                = byte_position + 8'd1;
    cmd                    = '0;

    if (!parse_halted) begin
      if (byte_position == 8'd0) begin
        descriptor_length_next = data_byte;
        if (data_byte == 8'd0) begin
          parse_halted_next = 1'b1;
        end
      end else if (byte_position == 8'd1) begin
        descriptor_type_next = data_byte;
      end else begin
        if (byte_position <= 8'd7) begin
          hold_we = 1'b1;
        end

        if (descriptor_type == TYPE_CONFIG &&
            byte_position == STD_LEN_CONFIG - 8'd1 &&
            descriptor_length >= STD_LEN_CONFIG) begin
          cmd.has_rec      = 1'b1;
          cmd.rec.kind     = KIND_CONFIG;
          cmd.rec.id_value = field_hold[3];
        end else if (descriptor_type == TYPE_INTERFACE &&
                     byte_position == STD_LEN_INTERFACE - 8'd1 &&
                     descriptor_length >= STD_LEN_INTERFACE) begin
          if (interface_count < IF_CNT_W'(MAX_INTERFACES)) begin
            cmd.has_rec            = 1'b1;
            cmd.rec.kind           = KIND_INTERFACE;
            cmd.rec.interface_slot = 4'(interface_count);
            cmd.rec.id_value       = field_hold[0];
            cmd.rec.alt_or_type    = field_hold[1];
            cmd.rec.iface_class    = field_hold[3];
            cmd.rec.subclass_code  = field_hold[4];
            cmd.rec.protocol_code  = field_hold[5];
            interface_count_next   = interface_count + IF_CNT_W'(1);
            have_interface_next    = 1'b1;
            endpoint_count_next    = '0;
          end
        end else if (descriptor_type == TYPE_ENDPOINT &&
                     byte_position == STD_LEN_ENDPOINT - 8'd1 &&
                     descriptor_length >= STD_LEN_ENDPOINT) begin
          if (have_interface && endpoint_count < EP_CNT_W'(MAX_ENDPOINTS)) begin
            cmd.has_rec            = 1'b1;
            cmd.rec.kind           = KIND_ENDPOINT;
            cmd.rec.interface_slot = 4'(interface_count - IF_CNT_W'(1));
            cmd.rec.endpoint_slot  = 4'(endpoint_count);
            cmd.rec.id_value       = field_hold[0] & EP_NUM_MASK;
            cmd.rec.alt_or_type    = field_hold[1] & XFER_TYPE_MASK;
            cmd.rec.direction_in   = (field_hold[0] & EP_DIR_BIT) != 8'd0;
            cmd.rec.ep_packet_size = {field_hold[3], field_hold[2]};
            cmd.rec.poll_interval  = data_byte;
            endpoint_count_next    = endpoint_count + EP_CNT_W'(1);
          end
        end
      end

      if (!parse_halted_next) begin
        // wrap to the next descriptor once its length is used up
        if (pos_inc >= descriptor_length_next) begin
          byte_position_next = 8'd0;
        end else begin
          byte_position_next = pos_inc;
        end
      end
    end

    if (last_byte) begin
      cmd.has_end            = 1'b1;
      cmd.end_count          = 4'(interface_count_next);
      byte_position_next     = 8'd0;
      descriptor_length_next = 8'd0;
      descriptor_type_next   = 8'd0;
      interface_count_next   = '0;
      have_interface_next    = 1'b0;
      endpoint_count_next    = '0;
      parse_halted_next      = 1'b0;
    end
  end

  assign cmd_valid = accept && (cmd.has_rec || cmd.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 8'd0;
      descriptor_length <= 8'd0;
      descriptor_type   <= 8'd0;
      interface_count   <= '0;
      have_interface    <= 1'b0;
      endpoint_count    <= '0;
      parse_halted      <= 1'b0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      descriptor_length <= descriptor_length_next;
      descriptor_type   <= descriptor_type_next;
      interface_count   <= interface_count_next;
      have_interface    <= have_interface_next;
      endpoint_count    <= endpoint_count_next;
      parse_halted      <= parse_halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      field_hold[hold_idx] <= data_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/ucdp_cmdq.sv]
// ----------------------------------------------------------------------------
// ucdp_cmdq
// short command queue between the byte tracker and the result stage
// ----------------------------------------------------------------------------
`default_nettype none

module ucdp_cmdq
  import ucdp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      q_full,
  output logic      q_empty
);

  cmd_t                entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr;
  logic [CMDQ_AW-1:0]  rd_ptr;
  logic [CMDQ_AW:0]    fill;

  assign q_full  = fill == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign q_empty = fill == '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + CMDQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + CMDQ_AW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + (CMDQ_AW+1)'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - (CMDQ_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/ucdp_back.sv]
// ----------------------------------------------------------------------------
// ucdp_back
// result stage: turns commands into records and holds the output register
// ----------------------------------------------------------------------------
`default_nettype none

module ucdp_back
  import ucdp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output rec_t      rec_out,
  output logic      last_of_run
);

  logic       out_valid;
  logic       end_pend;
  logic [3:0] end_cnt;
  logic       load;

  function automatic rec_t end_rec(input logic [3:0] count);
    rec_t r;
    r                = '0;
    r.kind           = KIND_END;
    r.interface_slot = count;
    return r;
  endfunction

  assign load  = !out_valid || pop;
  assign q_pop = load && !end_pend && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      end_pend  <= 1'b0;
    end else if (load) begin
      if (end_pend) begin
        out_valid <= 1'b1;
        end_pend  <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        end_pend  <= q_head.has_rec && q_head.has_end;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (end_pend) begin
        rec_out     <= end_rec(end_cnt);
        last_of_run <= 1'b1;
      end else if (!q_empty) begin
        end_cnt <= q_head.end_count;
        if (q_head.has_rec) begin
          rec_out     <= q_head.rec;
          last_of_run <= !q_head.has_end;
        end else begin
          rec_out     <= end_rec(q_head.end_count);
          last_of_run <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/usb_config_descriptor_parser.sv]
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser
// parses a usb configuration descriptor set byte by byte into records
// ----------------------------------------------------------------------------
// path: a byte's first record is written into the queue at its transfer and
//   moves into the output register when the result stage loads it
// throughput: one byte per cycle while the queue is not full; a byte that closes
//   a descriptor and is the last byte gives two records, absorbed by the queue
// reset: synchronous, clears parse state, queue pointers and the output valid
//   flag; the held descriptor bytes and the output record are not cleared
`default_nettype none

module usb_config_descriptor_parser
  import ucdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte side
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // record side
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       record_kind,
  output logic [3:0]       interface_slot,
  output logic [3:0]       endpoint_slot,
  output logic [7:0]       id_value,
  output logic [7:0]       alt_or_type,
  output logic [7:0]       iface_class,
  output logic [7:0]       subclass_code,
  output logic [7:0]       protocol_code,
  output logic             direction_in,
  output logic [15:0]      ep_packet_size,
  output logic [7:0]       poll_interval,
  output logic             last_of_run
);

  // command from the tracker into the queue
  logic cmd_valid;
  cmd_t cmd;

  // queue head into the result stage
  cmd_t q_head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  rec_t rec_q;

  // the byte side stalls only when the command queue is full
  assign full = q_full;

  // front: position tracking, field capture and record classification
  ucdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // decoupling queue; only bytes that give a record or end the set enter
  ucdp_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: splits record plus end into two transfers, holds the result
  ucdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .rec_out     (rec_q),
    .last_of_run (last_of_run)
  );

  // unpack the held record onto its field ports
  assign record_kind    = rec_q.kind;
  assign interface_slot = rec_q.interface_slot;
  assign endpoint_slot  = rec_q.endpoint_slot;
  assign id_value       = rec_q.id_value;
  assign alt_or_type    = rec_q.alt_or_type;
  assign iface_class    = rec_q.iface_class;
  assign subclass_code  = rec_q.subclass_code;
  assign protocol_code  = rec_q.protocol_code;
  assign direction_in   = rec_q.direction_in;
  assign ep_packet_size = rec_q.ep_packet_size;
  assign poll_interval  = rec_q.poll_interval;

endmodule

`default_nettype wire
